@@ rtl/core/gmag_pkg.sv @@
package gmag_pkg;

   localparam int DEF_MAX_WIDTH = 2048;

   localparam logic [1:0]  MODE_SOBEL   = 2'd0;
   localparam logic [1:0]  MODE_SCHARR  = 2'd1;
   localparam logic [1:0]  MODE_PREWITT = 2'd2;
   localparam logic [1:0]  RESET_MODE   = MODE_SOBEL;
   localparam logic [11:0] RESET_WIDTH  = 12'd640;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_WIDTH = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // 3x3 luma window: [row][col], row 0 is the top row
   typedef logic [2:0][2:0][7:0] win_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CAPTURE,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/core/gmag_ram.sv @@
module gmag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/gmag_grad.sv @@
module gmag_grad (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              mode,
   input  gmag_pkg::win_type       win,
   output logic                    done,
   output logic [7:0]              mag
);
   import gmag_pkg::*;

   logic               busy_ff;
   logic [3:0]         step_ff;
   logic               done_ff;
   logic [11:0]        ax_ff, ay_ff;
   logic [23:0]        sqx_ff, sqy_ff;
   logic               sat_ff;
   logic [15:0]        v_ff;
   logic [7:0]         res_ff;
   logic signed [12:0] gv, gh;
   logic [24:0]        sum;
   logic [2:0]         bit_idx;
   logic [7:0]         trial;
   logic [15:0]        trial_sq;

   // weight one difference term by the kernel tap (pos 1 is the middle tap)
   function automatic logic signed [12:0] kmul(input logic [1:0] m,
                                                input logic signed [8:0] d,
                                                input logic mid);
      logic signed [12:0] e;
      e = 13'(d);
      case (m)
         MODE_SCHARR:  kmul = mid ? ((e <<< 3) + (e <<< 1)) : ((e <<< 1) + e);
         MODE_PREWITT: kmul = e;
         default:      kmul = mid ? (e <<< 1) : e;
      endcase
   endfunction

   always_comb begin
      gv = '0;
      gh = '0;
      for (int i = 0; i < 3; i++) begin
         gv = gv + kmul(mode, $signed({1'b0, win[2][i]}) - $signed({1'b0, win[0][i]}),
                        i == 1);
         gh = gh + kmul(mode, $signed({1'b0, win[i][2]}) - $signed({1'b0, win[i][0]}),
                        i == 1);
      end
   end

   assign sum      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign bit_idx  = 3'(4'd9 - step_ff);
   assign trial    = res_ff | (8'd1 << bit_idx);
   assign trial_sq = trial * trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd9) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff <= gv < 0 ? 12'(-gv) : 12'(gv);
         ay_ff <= gh < 0 ? 12'(-gh) : 12'(gh);
      end else if (busy_ff) begin
         if (step_ff == 4'd0) begin
            sqx_ff <= ax_ff * ax_ff;
            sqy_ff <= ay_ff * ay_ff;
         end else if (step_ff == 4'd1) begin
            sat_ff <= sum[24:16] != '0;
            v_ff   <= sum[15:0];
            res_ff <= '0;
         end else if (trial_sq <= v_ff) begin
            // one result bit per cycle, msb first
            res_ff <= trial;
         end
      end
   end

   assign done = done_ff;
   assign mag  = sat_ff ? 8'd255 : res_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy_ff) && !busy_ff) else $error("done without a pass");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("start while busy");
   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= 4'd9) else $error("step overrun");
endmodule

@@ rtl/core/gradient_magnitude_3x3.sv @@
// Streaming 3x3 gradient magnitude. Each RGB request is turned into luma
// (77R+150G+29B)>>8, pushed through two line stores and a 3x3 window, and
// filtered by the Sobel, Scharr or Prewitt pair chosen in operator_mode;
// each result is floor(sqrt(gx^2+gy^2)) saturated at 255. Results trail the
// input by one row, borders repeat the edge pixel, and flush requests drain
// the last row one column each. Requests are handled one at a time: a pixel
// takes a line store read and update, then one gradient pass for each
// result it yields; a flush takes three line store reads, then one pass. A
// result that waits for the consumer holds up the next request. The pace is
// set by the shared gradient unit, which works out the square root one bit
// per cycle, and by the one read port of each line store. Results wait in
// an output register until taken. The line stores need no clearing after reset.
// Configuration writes (csr_index 0 operator_mode, 1 image_width) are taken
// at any time but are meant for an idle block.
module gradient_magnitude_3x3 #(
   parameter int MAX_WIDTH = gmag_pkg::DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_magnitude,
   output logic        rsp_line_end,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   import gmag_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   state_type      state_ff, state_in;
   logic [1:0]     mode_ff;
   logic [11:0]    width_ff;
   logic [AW-1:0]  col_ff, flush_col_ff;
   logic [1:0]     rows_ff;
   logic [CW-1:0]  eff;

   // latched request
   logic           item_flush_ff;
   logic [7:0]     item_r_ff, item_g_ff, item_b_ff;
   logic [AW-1:0]  item_col_ff;
   logic [1:0]     item_rows_ff;
   logic           item_end_ff;
   logic [1:0]     rd_col_ff;

   win_type        win_ff, tmp_ff, end_win, job_win;
   logic           pend_a_ff, pend_b_ff, pend_f_ff;

   logic           req_fire, rsp_fire;
   logic [AW-1:0]  acc_col;
   logic [1:0]     acc_rows;
   logic           acc_end, flush_idle;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [7:0]     older_rd, newer_rd, luma, top_px, mid_px;
   logic [15:0]    luma_sum;
   logic           grad_start, grad_done;
   logic [7:0]     grad_mag;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;

   // effective width: zero acts as one, clip to the line store depth
   always_comb begin
      if (width_ff == '0) begin
         eff = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff = CW'(MAX_WIDTH);
      end else begin
         eff = CW'(width_ff);
      end
   end

   // position of the accepted request: a pixel frame start clears the counters
   always_comb begin
      if (req_op == OP_FLUSH) begin
         acc_col  = flush_col_ff;
         acc_rows = rows_ff;
      end else if (req_frame_start) begin
         acc_col  = '0;
         acc_rows = '0;
      end else begin
         acc_col  = col_ff;
         acc_rows = rows_ff;
      end
      acc_end    = (CW'(acc_col) + CW'(1)) >= eff;
      flush_idle = (rows_ff == 2'd0) || (col_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= RESET_MODE;
         width_ff <= RESET_WIDTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:  mode_ff  <= csr_data[1:0];
            REG_WIDTH: width_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   // row and column bookkeeping advances as soon as the request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         rows_ff      <= '0;
         flush_col_ff <= '0;
      end else if (req_fire) begin
         if (req_op == OP_FLUSH) begin
            if (!flush_idle) begin
               flush_col_ff <= acc_end ? '0 : AW'(acc_col + 1'b1);
               if (acc_end) begin
                  rows_ff <= '0;
               end
            end
         end else begin
            if (acc_end) begin
               col_ff       <= '0;
               rows_ff      <= (acc_rows == 2'd2) ? 2'd2 : acc_rows + 2'd1;
               flush_col_ff <= '0;
            end else begin
               col_ff       <= AW'(acc_col + 1'b1);
               rows_ff      <= acc_rows;
               flush_col_ff <= req_frame_start ? '0 : flush_col_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_flush_ff <= req_op;
         item_r_ff     <= req_red;
         item_g_ff     <= req_green;
         item_b_ff     <= req_blue;
         item_col_ff   <= acc_col;
         item_rows_ff  <= acc_rows;
         item_end_ff   <= acc_end;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !(req_op == OP_FLUSH && flush_idle)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_CAPTURE;
         ST_CAPTURE: begin
            if (item_flush_ff) begin
               state_in = (rd_col_ff == 2'd2) ? ST_START : ST_READ;
            end else if (item_rows_ff != 2'd0 && (item_col_ff != '0 || item_end_ff)) begin
               state_in = ST_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (grad_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               state_in = (pend_a_ff || pend_b_ff || pend_f_ff) ? ST_START : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      grad_start = (state_ff == ST_START);
      wr_en      = (state_ff == ST_CAPTURE) && !item_flush_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // line store address: the pixel column, or the three flush columns in turn
   always_comb begin
      rd_addr = item_col_ff;
      if (item_flush_ff) begin
         case (rd_col_ff)
            2'd0:    rd_addr = (item_col_ff == '0) ? '0 : AW'(item_col_ff - 1'b1);
            2'd2:    rd_addr = item_end_ff ? item_col_ff : AW'(item_col_ff + 1'b1);
            default: rd_addr = item_col_ff;
         endcase
      end
   end

   assign luma_sum = 16'(item_r_ff) * 16'd77 + 16'(item_g_ff) * 16'd150
                   + 16'(item_b_ff) * 16'd29;
   assign luma     = luma_sum[15:8];
   assign mid_px   = newer_rd;
   // top border: repeat the center row until two rows are stored
   assign top_px   = (item_rows_ff == 2'd2) ? older_rd : newer_rd;

   gmag_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_col_ff),
      .wr_data (mid_px),
      .rd_addr (rd_addr),
      .rd_data (older_rd)
   );

   gmag_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_col_ff),
      .wr_data (luma),
      .rd_addr (rd_addr),
      .rd_data (newer_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_col_ff <= '0;
      end else if (state_ff == ST_IDLE) begin
         rd_col_ff <= '0;
      end else if (state_ff == ST_CAPTURE) begin
         rd_col_ff <= rd_col_ff + 2'd1;
      end
   end

   // window shift on a pixel; flush columns gather into a side window
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (state_ff == ST_CAPTURE && !item_flush_ff) begin
         for (int i = 0; i < 3; i++) begin
            logic [7:0] v;
            v = (i == 0) ? top_px : (i == 1) ? mid_px : luma;
            if (item_col_ff == '0) begin
               win_ff[i][0] <= v;
               win_ff[i][1] <= v;
               win_ff[i][2] <= v;
            end else begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
               win_ff[i][2] <= v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CAPTURE && item_flush_ff) begin
         // bottom border: the row below repeats the last row
         tmp_ff[0][rd_col_ff] <= top_px;
         tmp_ff[1][rd_col_ff] <= mid_px;
         tmp_ff[2][rd_col_ff] <= mid_px;
      end
   end

   // right border window: repeat the last column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         end_win[i][0] = win_ff[i][1];
         end_win[i][1] = win_ff[i][2];
         end_win[i][2] = win_ff[i][2];
      end
      if (pend_f_ff) begin
         job_win = tmp_ff;
      end else if (pend_a_ff) begin
         job_win = win_ff;
      end else begin
         job_win = end_win;
      end
   end

   gmag_grad u_grad (
      .clock (clock),
      .reset (reset),
      .start (grad_start),
      .mode  (mode_ff),
      .win   (job_win),
      .done  (grad_done),
      .mag   (grad_mag)
   );

   // pending results of the current request; drop each once computed
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
         pend_f_ff <= 1'b0;
      end else if (req_fire) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
         pend_f_ff <= (req_op == OP_FLUSH) && !flush_idle;
      end else if (state_ff == ST_CAPTURE && !item_flush_ff) begin
         pend_a_ff <= (item_rows_ff != 2'd0) && (item_col_ff != '0);
         pend_b_ff <= (item_rows_ff != 2'd0) && item_end_ff;
      end else if (grad_done) begin
         if (pend_f_ff) begin
            pend_f_ff <= 1'b0;
         end else if (pend_a_ff) begin
            pend_a_ff <= 1'b0;
         end else begin
            pend_b_ff <= 1'b0;
         end
      end
   end

   // output register: hold the result until the consumer takes it
   logic rsp_valid_ff, rsp_line_end_ff, rsp_last_ff;
   logic [7:0] rsp_mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (grad_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (grad_done) begin
         rsp_mag_ff <= grad_mag;
         if (pend_f_ff) begin
            rsp_line_end_ff <= item_end_ff;
            rsp_last_ff     <= 1'b1;
         end else if (pend_a_ff) begin
            rsp_line_end_ff <= 1'b0;
            rsp_last_ff     <= !pend_b_ff;
         end else begin
            rsp_line_end_ff <= 1'b1;
            rsp_last_ff     <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_magnitude   = rsp_mag_ff;
   assign rsp_line_end    = rsp_line_end_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_EMIT) else $error("result outside emit");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      grad_done |-> state_ff == ST_WAIT) else $error("gradient done unexpectedly");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !rsp_valid && !pend_a_ff && !pend_b_ff && !pend_f_ff)
      else $error("request taken while busy");
   a_one_flush_job: assert property (@(posedge clock) disable iff (reset)
      pend_f_ff |-> !pend_a_ff && !pend_b_ff) else $error("mixed jobs");
endmodule
